// ===== design/spectral_norm_power_iteration_defines.svh =====
// assertion macros for the spectral norm power iteration block
// expects clk_i and rst_ni in the scope of each use
`ifndef SPECTRAL_NORM_POWER_ITERATION_DEFINES_SVH
`define SPECTRAL_NORM_POWER_ITERATION_DEFINES_SVH

// property checked on every rising edge outside reset
`define SNPI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// antecedent followed in the next cycle by the consequent
`define SNPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/snpi_pkg.sv =====
// shared constants, codes and types of the spectral norm power iteration block
// no dependencies
`timescale 1ns / 1ps

package snpi_pkg;

  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;

  // payload widths
  localparam int ACTW = 3;
  localparam int IDXW = 6;
  localparam int VW   = 16;
  localparam int RESW = 32;

  // configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] REG_ROWS  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_COLS  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ITERS = 3'd2;
  localparam logic [CFG_IW-1:0] REG_EPS   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_GAIN  = 3'd4;

  localparam logic [ACTW-1:0] ACT_LD_W  = 3'd0;
  localparam logic [ACTW-1:0] ACT_LD_U  = 3'd1;
  localparam logic [ACTW-1:0] ACT_LD_V  = 3'd2;
  localparam logic [ACTW-1:0] ACT_FEAT  = 3'd3;
  localparam logic [ACTW-1:0] ACT_QUERY = 3'd4;

  // internal widths, sized for sixty-four rows and columns
  localparam int CW    = 7;   // sizes and counters
  localparam int ITW   = 8;
  localparam int EPSW  = 15;
  localparam int TW    = 26;  // rounded matrix-vector element
  localparam int DW    = 38;  // exact dot product
  localparam int ACCW  = 60;  // accumulators
  localparam int OPW   = 27;  // multiplier operand
  localparam int PW    = 54;  // multiplier product
  localparam int SPLIT = 24;  // low chunk of a wide dot product
  localparam int SUMW  = 56;  // sum of squares, even
  localparam int ROOTW = SUMW / 2;
  localparam int NUMW  = 53;
  localparam int DENW  = 35;
  localparam int SIGW  = 31;

  typedef struct packed {
    logic            start;
    logic [NUMW-1:0] num;
    logic [DENW-1:0] den;
  } div_req_t;

endpackage

// ===== design/snpi_in_if.sv =====
// input channel of the spectral norm block: handshake and item fields
// depends on snpi_pkg
`timescale 1ns / 1ps

interface snpi_in_if;
  logic                                valid;
  logic                                ready;
  logic        [snpi_pkg::ACTW-1:0]    action;
  logic        [snpi_pkg::IDXW-1:0]    row;
  logic        [snpi_pkg::IDXW-1:0]    col;
  logic signed [snpi_pkg::VW-1:0]      value;
  logic                                last;

  modport source (output valid, action, row, col, value, last, input ready);
  modport sink   (input valid, action, row, col, value, last, output ready);
endinterface

// ===== design/snpi_out_if.sv =====
// result channel of the spectral norm block: handshake and result fields
// depends on snpi_pkg
`timescale 1ns / 1ps

interface snpi_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [snpi_pkg::RESW-1:0]    result;
  logic        [snpi_pkg::IDXW-1:0]    index;
  logic                                is_sigma;
  logic                                last_res;

  modport source (output valid, result, index, is_sigma, last_res, input ready);
  modport sink   (input valid, result, index, is_sigma, last_res, output ready);
endinterface

// ===== design/snpi_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
// depends on snpi_pkg
`timescale 1ns / 1ps

module snpi_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  snpi_pkg::div_req_t         req_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [snpi_pkg::NUMW-1:0]  quo_o
);
  localparam int NUMW = snpi_pkg::NUMW;
  localparam int DENW = snpi_pkg::DENW;
  localparam int CNTW = $clog2(NUMW + 1);

  logic [NUMW-1:0] quo_q;
  logic [DENW-1:0] rem_q;
  logic [DENW-1:0] den_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [DENW:0]   trial;
  logic            fits;

  assign trial = {rem_q, quo_q[NUMW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(NUMW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DENW'(trial - {1'b0, den_q}) : DENW'(trial);
      quo_q <= {quo_q[NUMW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// ===== design/snpi_sqrt.sv =====
// integer square root, two radicand bits per cycle
// depends on snpi_pkg
`timescale 1ns / 1ps

module snpi_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [snpi_pkg::SUMW-1:0]   x_i,
  output logic                        done_o,
  output logic [snpi_pkg::ROOTW-1:0]  root_o
);
  localparam int SUMW  = snpi_pkg::SUMW;
  localparam int ROOTW = snpi_pkg::ROOTW;
  localparam int REMW  = ROOTW + 2;
  localparam int CNTW  = $clog2(ROOTW + 1);

  logic [SUMW-1:0]  x_q;
  logic [ROOTW-1:0] root_q;
  logic [REMW-1:0]  rem_q;
  logic [CNTW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [REMW+1:0]  cur;
  logic [REMW+1:0]  trial;
  logic             fits;

  assign cur   = {rem_q, x_q[SUMW-1 -: 2]};
  assign trial = (REMW + 2)'({root_q, 2'b01});
  assign fits  = cur >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(ROOTW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      x_q    <= x_q << 2;
      rem_q  <= fits ? REMW'(cur - trial) : REMW'(cur);
      root_q <= {root_q[ROOTW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

// ===== design/spectral_norm_power_iteration.sv =====
// spectral normalisation by warm-started power iteration, top level
// depends on snpi_pkg, snpi_in_if, snpi_out_if, snpi_div, snpi_sqrt and the defines header
//
// Usage: one input channel takes items (load weight, load u or v element,
// input feature, query sigma); one result channel gives Q16.16 results.
// Configuration registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i; the user must write them only while the block is idle,
// which the block does not enforce. Loads and features without last
// leave the block idle and ready for the next item. A query or a final
// feature runs the sequencer: each power iteration does the two
// matrix-vector products and sums of squares on the multiplier, a square
// root per product and a division per normalised element; sigma and each
// output feature follow, all paced by one shared multiplier and one
// shared bit-serial divider. in ready is low during that run.
// Results leave through an output register: while the receiver stalls the
// sequencer holds at the next result, and once the last result is in the
// register the block takes new items again.
// Reset clears the control state, restores the register defaults and
// clears the valid bits of u and v so both read as zero; the weight store
// and the feature row are undefined until written. No clearing pass.
`timescale 1ns / 1ps
`include "spectral_norm_power_iteration_defines.svh"

module spectral_norm_power_iteration #(
  parameter int MAX_ROWS = snpi_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = snpi_pkg::MAX_COLS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  snpi_in_if.sink                       in_if,
  snpi_out_if.source                    out_if,
  input  logic                          cfg_we_i,
  input  logic [snpi_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic [snpi_pkg::CFG_DW-1:0]   cfg_data_i
);
  localparam int CW     = snpi_pkg::CW;
  localparam int VW     = snpi_pkg::VW;
  localparam int TW     = snpi_pkg::TW;
  localparam int DW     = snpi_pkg::DW;
  localparam int ACCW   = snpi_pkg::ACCW;
  localparam int OPW    = snpi_pkg::OPW;
  localparam int PW     = snpi_pkg::PW;
  localparam int SPLIT  = snpi_pkg::SPLIT;
  localparam int SUMW   = snpi_pkg::SUMW;
  localparam int ROOTW  = snpi_pkg::ROOTW;
  localparam int NUMW   = snpi_pkg::NUMW;
  localparam int DENW   = snpi_pkg::DENW;
  localparam int SIGW   = snpi_pkg::SIGW;
  localparam int RESW   = snpi_pkg::RESW;
  localparam int IDXW   = snpi_pkg::IDXW;
  localparam int ITW    = snpi_pkg::ITW;
  localparam int EPSW   = snpi_pkg::EPSW;
  localparam int RAW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int MAXV   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int TAW    = (MAXV > 1) ? $clog2(MAXV) : 1;
  localparam int WDEPTH = MAX_ROWS * MAX_COLS;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam logic [CW-1:0] ROWS_MAX = CW'(MAX_ROWS);
  localparam logic [CW-1:0] COLS_MAX = CW'(MAX_COLS);
  localparam logic [RESW-1:0] RES_MAX = {1'b0, {(RESW-1){1'b1}}};
  localparam logic [RESW-1:0] RES_MIN = {1'b1, {(RESW-1){1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE, S_ITER, S_MAC, S_DOT, S_SQRT, S_SQWT, S_NRD, S_NDV, S_NWT, S_NEXT,
    S_WM0, S_WM1, S_WM2, S_Q, S_ODIV, S_OWT, S_OPUT
  } state_e;

  typedef enum logic [1:0] {P_V, P_U, P_SIG, P_OUT} pass_e;

  // configuration
  logic        [CW-1:0]   rows_q, cols_q;
  logic        [ITW-1:0]  iters_q;
  logic        [EPSW-1:0] eps_q;
  logic signed [VW-1:0]   gain_q;
  logic        [CW-1:0]   rows_eff, cols_eff;

  // sequencer
  state_e                 state_q;
  pass_e                  pass_q;
  logic                   sq_q, want_out_q, s1_q, s2_q;
  logic        [CW-1:0]   k_q, oi_q, mac_n_q, out_n_q;
  logic        [ITW-1:0]  it_q;
  logic signed [ACCW-1:0] acc_q, wacc_q;
  logic signed [DW-1:0]   dot_q;
  logic        [ROOTW-1:0] norm_q;
  logic        [SIGW-1:0] sigma_q;
  logic        [RESW-1:0] y_q;
  logic                   mac_issue, mac_idle;

  // output register
  logic                   out_valid_q;
  logic signed [RESW-1:0] out_result_q;
  logic        [IDXW-1:0] out_index_q;
  logic                   out_is_sigma_q, out_last_q;

  // stores and read registers
  logic signed [VW-1:0]   w_mem [WDEPTH];
  logic signed [VW-1:0]   u_mem [MAX_ROWS];
  logic signed [VW-1:0]   v_mem [MAX_COLS];
  logic signed [VW-1:0]   x_mem [MAX_COLS];
  logic signed [TW-1:0]   t_mem [MAXV];
  logic        [MAX_ROWS-1:0] u_vld_q;
  logic        [MAX_COLS-1:0] v_vld_q;
  logic signed [VW-1:0]   wt_rd_q, u_rd_q, v_rd_q, x_rd_q;
  logic signed [TW-1:0]   t_rd_q;

  logic                   acc_in, row_ok, col_ok, nrm_we, w_we, x_we, t_we, u_we, v_we;
  logic        [WAW-1:0]  w_raddr, w_waddr;
  logic        [RAW-1:0]  u_raddr, u_waddr;
  logic        [CAW-1:0]  v_waddr;
  logic signed [VW-1:0]   u_wdata, v_wdata;

  // shared multiplier
  logic signed [OPW-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]   prod_q;
  logic signed [VW-1:0]   wm_a;

  // arithmetic around the sequencer
  logic signed [DW-1:0]   dot_s;
  logic        [DW-1:0]   dot_mag, dot_rnd;
  logic signed [TW-1:0]   t_val;
  logic        [TW-1:0]   t_mag;
  logic        [NUMW-1:0] nrm_num, out_num;
  logic signed [VW-1:0]   nrm_val;
  logic        [ACCW-1:0] w_mag;
  logic        [ACCW-20-1:0] sig_rnd;
  logic        [SIGW-1:0] sig_sat, sigma_d;
  logic        [SIGW-1:0] sig_floor;
  logic        [DENW-1:0] out_den;
  logic        [RESW-1:0] y_div, y_zero;

  snpi_pkg::div_req_t     div_req;
  logic                   div_busy, div_done;
  logic        [NUMW-1:0] div_quo;
  logic                   sqrt_start, sqrt_done;
  logic        [ROOTW-1:0] sqrt_root;

  function automatic logic [WAW-1:0] waddr(input logic [RAW-1:0] r, input logic [CAW-1:0] c);
    return WAW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= CW'(16);
      cols_q  <= CW'(16);
      iters_q <= ITW'(1);
      eps_q   <= EPSW'(1);
      gain_q  <= VW'(4096);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        snpi_pkg::REG_ROWS:  rows_q  <= cfg_data_i[CW-1:0];
        snpi_pkg::REG_COLS:  cols_q  <= cfg_data_i[CW-1:0];
        snpi_pkg::REG_ITERS: iters_q <= cfg_data_i[ITW-1:0];
        snpi_pkg::REG_EPS:   eps_q   <= cfg_data_i[EPSW-1:0];
        snpi_pkg::REG_GAIN:  gain_q  <= $signed(cfg_data_i[VW-1:0]);
        default: ;
      endcase
    end
  end

  assign rows_eff = (rows_q == '0) ? CW'(1) : ((rows_q > ROWS_MAX) ? ROWS_MAX : rows_q);
  assign cols_eff = (cols_q == '0) ? CW'(1) : ((cols_q > COLS_MAX) ? COLS_MAX : cols_q);

  // ---------------------------------------------------------------- stores
  assign in_if.ready = (state_q == S_IDLE);
  assign acc_in      = in_if.valid && in_if.ready;
  assign row_ok      = CW'(in_if.row) < ROWS_MAX;
  assign col_ok      = CW'(in_if.col) < COLS_MAX;
  assign nrm_we      = (state_q == S_NWT) && div_done;

  assign w_we    = acc_in && (in_if.action == snpi_pkg::ACT_LD_W) && row_ok && col_ok;
  assign x_we    = acc_in && (in_if.action == snpi_pkg::ACT_FEAT) && col_ok;
  assign t_we    = (state_q == S_DOT) && (pass_q == P_V || pass_q == P_U);
  assign u_we    = (acc_in && (in_if.action == snpi_pkg::ACT_LD_U) && row_ok) ||
                   (nrm_we && pass_q == P_U);
  assign v_we    = (acc_in && (in_if.action == snpi_pkg::ACT_LD_V) && col_ok) ||
                   (nrm_we && pass_q == P_V);
  assign u_waddr = nrm_we ? k_q[RAW-1:0] : in_if.row[RAW-1:0];
  assign v_waddr = nrm_we ? k_q[CAW-1:0] : in_if.col[CAW-1:0];
  assign u_wdata = nrm_we ? nrm_val : in_if.value;
  assign v_wdata = nrm_we ? nrm_val : in_if.value;
  assign w_waddr = waddr(in_if.row[RAW-1:0], in_if.col[CAW-1:0]);

  // the v pass walks a column, every other pass walks a row
  assign w_raddr = (pass_q == P_V) ? waddr(k_q[RAW-1:0], oi_q[CAW-1:0])
                                   : waddr(oi_q[RAW-1:0], k_q[CAW-1:0]);
  assign u_raddr = (pass_q == P_V) ? k_q[RAW-1:0] : oi_q[RAW-1:0];

  always_ff @(posedge clk_i) begin
    if (w_we) w_mem[w_waddr] <= in_if.value;
    wt_rd_q <= w_mem[w_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (u_we) u_mem[u_waddr] <= u_wdata;
    u_rd_q <= u_vld_q[u_raddr] ? u_mem[u_raddr] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (v_we) v_mem[v_waddr] <= v_wdata;
    v_rd_q <= v_vld_q[k_q[CAW-1:0]] ? v_mem[k_q[CAW-1:0]] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (x_we) x_mem[in_if.col[CAW-1:0]] <= in_if.value;
    x_rd_q <= x_mem[k_q[CAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (t_we) t_mem[oi_q[TAW-1:0]] <= t_val;
    t_rd_q <= t_mem[k_q[TAW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_vld_q <= '0;
      v_vld_q <= '0;
    end else begin
      if (u_we) u_vld_q[u_waddr] <= 1'b1;
      if (v_we) v_vld_q[v_waddr] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- multiplier
  assign wm_a = (pass_q == P_SIG) ? u_rd_q : gain_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MAC: begin
        if (sq_q) begin
          mul_a = OPW'(t_rd_q);
          mul_b = OPW'(t_rd_q);
        end else begin
          mul_a = OPW'(wt_rd_q);
          case (pass_q)
            P_V:     mul_b = OPW'(u_rd_q);
            P_OUT:   mul_b = OPW'(x_rd_q);
            default: mul_b = OPW'(v_rd_q);
          endcase
        end
      end
      S_WM0: begin
        mul_a = OPW'(wm_a);
        mul_b = OPW'($signed({1'b0, dot_q[SPLIT-1:0]}));
      end
      S_WM1: begin
        mul_a = OPW'(wm_a);
        mul_b = OPW'($signed(dot_q[DW-1:SPLIT]));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // ---------------------------------------------------------------- arithmetic
  // rounding of a dot product to Q.12, half away from zero
  assign dot_s   = $signed(acc_q[DW-1:0]);
  assign dot_mag = dot_s[DW-1] ? DW'(-dot_s) : DW'(dot_s);
  assign dot_rnd = (dot_mag + DW'(2048)) >> 12;
  assign t_val   = dot_s[DW-1] ? -$signed(TW'(dot_rnd)) : $signed(TW'(dot_rnd));

  // normalised element
  assign t_mag   = t_rd_q[TW-1] ? TW'(-t_rd_q) : TW'(t_rd_q);
  assign nrm_num = (NUMW'(t_mag) << 12) + NUMW'(norm_q >> 1);
  always_comb begin
    if (t_rd_q[TW-1]) begin
      nrm_val = (div_quo > NUMW'(32768)) ? $signed(VW'(16'h8000))
                                         : -$signed(VW'(div_quo));
    end else begin
      nrm_val = (div_quo > NUMW'(32767)) ? $signed(VW'(16'h7fff))
                                         : $signed(VW'(div_quo));
    end
  end

  // sigma from the Q.36 sum
  assign w_mag     = wacc_q[ACCW-1] ? ACCW'(-wacc_q) : ACCW'(wacc_q);
  assign sig_rnd   = (ACCW-20)'((w_mag + (ACCW'(1) << 19)) >> 20);
  assign sig_sat   = (sig_rnd > (ACCW-20)'({SIGW{1'b1}})) ? {SIGW{1'b1}} : SIGW'(sig_rnd);
  assign sig_floor = SIGW'({eps_q, 4'b0000});
  assign sigma_d   = (sig_sat < sig_floor) ? sig_floor : sig_sat;

  // output feature
  assign out_den = {sigma_q, 4'b0000};
  assign out_num = NUMW'(w_mag) + NUMW'(out_den >> 1);
  always_comb begin
    if (wacc_q[ACCW-1]) begin
      y_div = (div_quo > (NUMW'(1) << (RESW-1))) ? RES_MIN : RESW'(-div_quo);
    end else begin
      y_div = (div_quo > NUMW'(RES_MAX)) ? RES_MAX : RESW'(div_quo);
    end
  end
  assign y_zero = wacc_q[ACCW-1] ? RES_MIN : ((wacc_q != '0) ? RES_MAX : '0);

  // ---------------------------------------------------------------- shared units
  assign sqrt_start    = (state_q == S_SQRT);
  assign div_req.start = (state_q == S_NDV) || (state_q == S_ODIV && sigma_q != '0);
  assign div_req.num   = (state_q == S_NDV) ? nrm_num : out_num;
  assign div_req.den   = (state_q == S_NDV) ? DENW'(norm_q) : out_den;

  snpi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (acc_q[SUMW-1:0]),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  snpi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // ---------------------------------------------------------------- sequencer
  assign mac_issue = k_q < mac_n_q;
  assign mac_idle  = !mac_issue && !s1_q && !s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= P_V;
      sq_q        <= 1'b0;
      want_out_q  <= 1'b0;
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
      k_q         <= '0;
      oi_q        <= '0;
      mac_n_q     <= '0;
      out_n_q     <= '0;
      it_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_if.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (acc_in && ((in_if.action == snpi_pkg::ACT_FEAT && in_if.last) ||
                         in_if.action == snpi_pkg::ACT_QUERY)) begin
            want_out_q <= (in_if.action == snpi_pkg::ACT_FEAT);
            it_q       <= '0;
            state_q    <= S_ITER;
          end
        end
        S_ITER: begin
          oi_q  <= '0;
          k_q   <= '0;
          s1_q  <= 1'b0;
          s2_q  <= 1'b0;
          acc_q <= '0;
          sq_q  <= 1'b0;
          state_q <= S_MAC;
          if (it_q < iters_q) begin
            pass_q  <= P_V;
            mac_n_q <= rows_eff;
            out_n_q <= cols_eff;
          end else begin
            pass_q  <= P_SIG;
            mac_n_q <= cols_eff;
            out_n_q <= rows_eff;
            wacc_q  <= '0;
          end
        end
        S_MAC: begin
          if (mac_issue) k_q <= k_q + 1'b1;
          s1_q <= mac_issue;
          s2_q <= s1_q;
          if (s2_q) acc_q <= acc_q + ACCW'(prod_q);
          if (mac_idle) state_q <= sq_q ? S_SQRT : S_DOT;
        end
        S_DOT: begin
          k_q   <= '0;
          acc_q <= '0;
          if (pass_q == P_V || pass_q == P_U) begin
            if (oi_q + 1'b1 == out_n_q) begin
              // all elements rounded, now the sum of squares
              sq_q    <= 1'b1;
              mac_n_q <= out_n_q;
            end else begin
              oi_q <= oi_q + 1'b1;
            end
            state_q <= S_MAC;
          end else begin
            dot_q <= dot_s;
            if (pass_q == P_OUT) wacc_q <= '0;
            state_q <= S_WM0;
          end
        end
        S_SQRT: begin
          state_q <= S_SQWT;
        end
        S_SQWT: begin
          if (sqrt_done) begin
            norm_q  <= sqrt_root;
            k_q     <= '0;
            state_q <= (sqrt_root > ROOTW'(eps_q)) ? S_NRD : S_NEXT;
          end
        end
        S_NRD: begin
          state_q <= S_NDV;
        end
        S_NDV: begin
          state_q <= S_NWT;
        end
        S_NWT: begin
          if (div_done) begin
            k_q     <= k_q + 1'b1;
            state_q <= (k_q + 1'b1 == out_n_q) ? S_NEXT : S_NRD;
          end
        end
        S_NEXT: begin
          if (pass_q == P_V) begin
            pass_q  <= P_U;
            oi_q    <= '0;
            k_q     <= '0;
            acc_q   <= '0;
            sq_q    <= 1'b0;
            mac_n_q <= cols_eff;
            out_n_q <= rows_eff;
            state_q <= S_MAC;
          end else begin
            it_q    <= it_q + 1'b1;
            state_q <= S_ITER;
          end
        end
        S_WM0: begin
          state_q <= S_WM1;
        end
        S_WM1: begin
          wacc_q  <= wacc_q + ACCW'(prod_q);
          state_q <= S_WM2;
        end
        S_WM2: begin
          wacc_q <= wacc_q + (ACCW'(prod_q) <<< SPLIT);
          if (pass_q == P_OUT) begin
            state_q <= S_ODIV;
          end else if (oi_q + 1'b1 == out_n_q) begin
            state_q <= S_Q;
          end else begin
            oi_q    <= oi_q + 1'b1;
            k_q     <= '0;
            acc_q   <= '0;
            state_q <= S_MAC;
          end
        end
        S_Q: begin
          sigma_q <= sigma_d;
          if (want_out_q) begin
            pass_q  <= P_OUT;
            oi_q    <= '0;
            k_q     <= '0;
            acc_q   <= '0;
            mac_n_q <= cols_eff;
            out_n_q <= rows_eff;
            state_q <= S_MAC;
          end else begin
            y_q     <= RESW'(sigma_d);
            state_q <= S_OPUT;
          end
        end
        S_ODIV: begin
          if (sigma_q == '0) begin
            y_q     <= y_zero;
            state_q <= S_OPUT;
          end else begin
            state_q <= S_OWT;
          end
        end
        S_OWT: begin
          if (div_done) begin
            y_q     <= y_div;
            state_q <= S_OPUT;
          end
        end
        S_OPUT: begin
          if (!out_valid_q || out_if.ready) begin
            out_valid_q    <= 1'b1;
            out_result_q   <= $signed(y_q);
            out_index_q    <= (pass_q == P_OUT) ? oi_q[IDXW-1:0] : '0;
            out_is_sigma_q <= (pass_q != P_OUT);
            out_last_q     <= (pass_q != P_OUT) || (oi_q + 1'b1 == out_n_q);
            if (pass_q == P_OUT && oi_q + 1'b1 != out_n_q) begin
              oi_q    <= oi_q + 1'b1;
              k_q     <= '0;
              acc_q   <= '0;
              state_q <= S_MAC;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid    = out_valid_q;
  assign out_if.result   = out_result_q;
  assign out_if.index    = out_index_q;
  assign out_if.is_sigma = out_is_sigma_q;
  assign out_if.last_res = out_last_q;

  // ---------------------------------------------------------------- checks
  `SNPI_ASSERT_NEXT(a_query_busy, acc_in && (in_if.action == snpi_pkg::ACT_QUERY), !in_if.ready, "query did not start a run")
  `SNPI_ASSERT(a_sigma_floor, ((state_q == S_ODIV) && (eps_q != '0)) |-> (sigma_q != '0), "sigma below floor")
  `SNPI_ASSERT(a_div_free, div_req.start |-> !div_busy, "divider restarted while busy")
endmodule

// ===== tb/sv/snpi_checker.sv =====
// result checker for the spectral norm block: predicts results from observed transactions
// depends on snpi_pkg, snpi_in_if and snpi_out_if
`timescale 1ns / 1ps

module snpi_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  snpi_in_if                          in_mon,
  snpi_out_if                         out_mon,
  input  logic                        cfg_we_i,
  input  logic [snpi_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [snpi_pkg::CFG_DW-1:0] cfg_data_i,
  output int                          fail_cnt_o,
  output int                          pending_o,
  output int                          items_o,
  output int                          results_o
);
  import snpi_pkg::*;

  localparam int NR = MAX_ROWS_DEF;
  localparam int NC = MAX_COLS_DEF;

  typedef struct {
    logic signed [31:0] result;
    logic [5:0]         index;
    logic               is_sigma;
    logic               last_res;
  } res_t;

  res_t expected_res_q[$];

  logic signed [15:0] w_mem [NR*NC];
  logic signed [15:0] u_vec [NR];
  logic signed [15:0] v_vec [NC];
  logic signed [15:0] x_row [NC];
  logic [6:0]         rows_reg, cols_reg;
  logic [7:0]         iters_reg;
  logic [14:0]        eps_reg;
  logic signed [15:0] gain_reg;

  function automatic longint unsigned mag(longint x);
    return x < 0 ? longint'(-x) : x;
  endfunction

  function automatic longint rshift12(longint x);
    longint m;
    m = longint'((mag(x) + 2048) >> 12);
    return x < 0 ? -m : m;
  endfunction

  function automatic longint div_rnd(longint num, longint unsigned den);
    longint m;
    m = longint'((mag(num) + den / 2) / den);
    return num < 0 ? -m : m;
  endfunction

  function automatic logic signed [15:0] clip16(longint x);
    if (x > 32767) return 16'sd32767;
    if (x < -32768) return -16'sd32768;
    return x[15:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int clamp_size(logic [6:0] v, int mx);
    if (v < 1) return 1;
    return v > mx ? mx : int'(v);
  endfunction

  function automatic longint dot_row(int i, int c, bit use_x);
    longint acc;
    acc = 0;
    for (int j = 0; j < c; j++)
      acc += longint'(w_mem[i*NC+j]) * longint'(use_x ? x_row[j] : v_vec[j]);
    return acc;
  endfunction

  // runs the power iterations on the shadow vectors and returns sigma in Q16.16
  function automatic longint sigma_update(int r, int c);
    longint tmp [NR+NC];
    longint acc, s;
    longint unsigned sq, nrm, q;
    for (int it = 0; it < int'(iters_reg); it++) begin
      sq = 0;
      for (int j = 0; j < c; j++) begin
        acc = 0;
        for (int i = 0; i < r; i++) acc += longint'(w_mem[i*NC+j]) * longint'(u_vec[i]);
        tmp[j] = rshift12(acc);
        sq += mag(tmp[j]) * mag(tmp[j]);
      end
      nrm = int_sqrt(sq);
      if (nrm > eps_reg)
        for (int j = 0; j < c; j++) v_vec[j] = clip16(div_rnd(tmp[j] * 4096, nrm));
      sq = 0;
      for (int i = 0; i < r; i++) begin
        tmp[i] = rshift12(dot_row(i, c, 1'b0));
        sq += mag(tmp[i]) * mag(tmp[i]);
      end
      nrm = int_sqrt(sq);
      if (nrm > eps_reg)
        for (int i = 0; i < r; i++) u_vec[i] = clip16(div_rnd(tmp[i] * 4096, nrm));
    end
    s = 0;
    for (int i = 0; i < r; i++) s += longint'(u_vec[i]) * dot_row(i, c, 1'b0);
    q = (mag(s) + (64'd1 << 19)) >> 20;
    if (q > 64'd2147483647) q = 64'd2147483647;
    if (q < (longint'(eps_reg) << 4)) q = longint'(eps_reg) << 4;
    return longint'(q);
  endfunction

  task automatic predict_item(logic [2:0] act, logic [5:0] row, logic [5:0] col,
                              logic signed [15:0] val, logic lst);
    int r, c;
    longint sig, num, y;
    res_t e;
    r = clamp_size(rows_reg, NR);
    c = clamp_size(cols_reg, NC);
    case (act)
      ACT_LD_W: if (row < NR && col < NC) w_mem[row*NC+col] = val;
      ACT_LD_U: if (row < NR) u_vec[row] = val;
      ACT_LD_V: if (col < NC) v_vec[col] = val;
      ACT_FEAT: begin
        if (col < NC) x_row[col] = val;
        if (lst) begin
          sig = sigma_update(r, c);
          for (int i = 0; i < r; i++) begin
            num = longint'(gain_reg) * dot_row(i, c, 1'b1);
            if (sig == 0) y = num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
            else begin
              y = div_rnd(num, longint'(sig) << 4);
              if (y > 64'sd2147483647) y = 64'sd2147483647;
              if (y < -64'sd2147483648) y = -64'sd2147483648;
            end
            e.result = y[31:0];
            e.index = i[5:0];
            e.is_sigma = 1'b0;
            e.last_res = (i + 1 == r);
            expected_res_q.push_back(e);
          end
        end
      end
      ACT_QUERY: begin
        sig = sigma_update(r, c);
        e.result = sig[31:0];
        e.index = '0;
        e.is_sigma = 1'b1;
        e.last_res = 1'b1;
        expected_res_q.push_back(e);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      expected_res_q.delete();
      for (int k = 0; k < NR*NC; k++) w_mem[k] = '0;
      for (int k = 0; k < NR; k++) u_vec[k] = '0;
      for (int k = 0; k < NC; k++) begin
        v_vec[k] = '0;
        x_row[k] = '0;
      end
      rows_reg = 7'd16;
      cols_reg = 7'd16;
      iters_reg = 8'd1;
      eps_reg = 15'd1;
      gain_reg = 16'sd4096;
      fail_cnt_o = 0;
      items_o = 0;
      results_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        results_o++;
        if (expected_res_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10)
            $display("unexpected result transaction: result %0d index %0d", out_mon.result,
                     out_mon.index);
        end else begin
          e = expected_res_q.pop_front();
          if (out_mon.result !== e.result || out_mon.index !== e.index ||
              out_mon.is_sigma !== e.is_sigma || out_mon.last_res !== e.last_res) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10)
              $display("mismatch: expected result %0d index %0d sigma %0b last %0b, got %0d %0d %0b %0b",
                       e.result, e.index, e.is_sigma, e.last_res, out_mon.result,
                       out_mon.index, out_mon.is_sigma, out_mon.last_res);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ROWS:  rows_reg = cfg_data_i[6:0];
          REG_COLS:  cols_reg = cfg_data_i[6:0];
          REG_ITERS: iters_reg = cfg_data_i[7:0];
          REG_EPS:   eps_reg = cfg_data_i[14:0];
          REG_GAIN:  gain_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        items_o++;
        predict_item(in_mon.action, in_mon.row, in_mon.col, in_mon.value, in_mon.last);
      end
    end
    pending_o = expected_res_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top for the spectral norm block: clock, reset, stimulus and verdict
// depends on snpi_pkg, the channel interfaces, snpi_checker and the block itself
`timescale 1ns / 1ps

module tb;
  import snpi_pkg::*;

  localparam int LIMIT = 4000000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i;
  logic [CFG_IW-1:0] cfg_idx_i;
  logic [CFG_DW-1:0] cfg_data_i;
  int                fail_cnt, pending, n_items, n_results;
  int                cycles = 0;
  int                burst_left = 0;
  int                stall_left = 0;
  int                rx_mode = 0;

  snpi_in_if  in_ch ();
  snpi_out_if out_ch ();

  spectral_norm_power_iteration i_dut (
    .clk_i, .rst_ni, .in_if(in_ch), .out_if(out_ch), .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  snpi_checker i_checker (
    .clk_i, .rst_ni, .in_mon(in_ch), .out_mon(out_ch), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .items_o(n_items), .results_o(n_results)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: always ready, random stalls or long stalls, with the mode drawn at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (cycles % 256 == 0) rx_mode = $urandom_range(0, 2);
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        default: begin
          if (stall_left > 0) stall_left--;
          else if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 25);
          out_ch.ready <= (stall_left == 0);
        end
      endcase
    end
  end

  task automatic send(logic [2:0] act, logic [5:0] row, logic [5:0] col,
                      logic [15:0] val, logic lst);
    int g;
    if (burst_left == 0) begin
      g = $urandom_range(0, 6);
      if (g > 0) begin
        in_ch.valid <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.row    <= row;
    in_ch.col    <= col;
    in_ch.value  <= val;
    in_ch.last   <= lst;
    do @(posedge clk_i); while (!in_ch.ready);
    burst_left--;
  endtask

  // hold off until every expected result has arrived and the block has settled
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_config(int r, int c, int it, int eps, int g);
    cfg_write(REG_ROWS, 16'(r));
    cfg_write(REG_COLS, 16'(c));
    cfg_write(REG_ITERS, 16'(it));
    cfg_write(REG_EPS, 16'(eps));
    cfg_write(REG_GAIN, 16'(g));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly weight and vector updates and feature rows, a few queries and noise
  task automatic random_items(int n, int cols);
    int p, fcol;
    fcol = 0;
    repeat (n) begin
      p = $urandom_range(0, 99);
      if (p < 35)
        send(ACT_LD_W, $urandom_range(0, 63), $urandom_range(0, 63), $urandom, $urandom);
      else if (p < 45)
        send(ACT_LD_U, $urandom_range(0, 63), $urandom, $urandom, $urandom);
      else if (p < 55)
        send(ACT_LD_V, $urandom, $urandom_range(0, 63), $urandom, $urandom);
      else if (p < 85) begin
        send(ACT_FEAT, $urandom, 6'(fcol), $urandom, fcol == cols - 1);
        fcol = (fcol + 1) % cols;
      end else if (p < 96)
        send(ACT_QUERY, $urandom, $urandom, $urandom, $urandom);
      else
        send(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom);
    end
    drain();
  endtask

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.action <= ACT_LD_W;
    in_ch.row    <= '0;
    in_ch.col    <= '0;
    in_ch.value  <= '0;
    in_ch.last   <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= REG_ROWS;
    cfg_data_i   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole weight store and feature row before anything reads them
    for (int i = 0; i < 16; i++)
      for (int j = 0; j < 16; j++)
        send(ACT_LD_W, 6'(i), 6'(j),
             (i == 0 && j == 0) ? 16'h7fff : (i == 15 && j == 15) ? 16'h8000 : 16'($urandom),
             1'b0);
    for (int j = 0; j < 16; j++) send(ACT_FEAT, '0, 6'(j), $urandom, 1'b0);

    // directed part at reset configuration
    send(ACT_LD_U, 6'd0, '0, 16'h7fff, 1'b0);
    send(ACT_LD_U, 6'd15, '0, 16'h8000, 1'b0);
    send(ACT_LD_U, 6'd40, '0, 16'h1234, 1'b0);
    send(ACT_LD_V, '0, 6'd0, 16'h8000, 1'b0);
    send(ACT_LD_V, '0, 6'd63, 16'h4321, 1'b0);
    send(ACT_LD_W, 6'd63, 6'd0, 16'h5555, 1'b0);
    send(3'd5, '0, '0, '0, 1'b1);
    send(3'd6, 6'h3f, 6'h3f, 16'hffff, 1'b1);
    send(3'd7, '0, '0, '0, 1'b0);
    send(ACT_FEAT, '0, 6'd3, 16'h7fff, 1'b0);
    send(ACT_FEAT, '0, 6'd15, 16'h8000, 1'b1);
    send(ACT_QUERY, '0, '0, '0, 1'b0);
    send(ACT_FEAT, '0, 6'd50, 16'h1111, 1'b1);
    drain();

    // single cell, many iterations, zero threshold: zero sigma then a proper one
    set_config(1, 1, 255, 0, 32767);
    send(ACT_LD_U, '0, '0, 16'h0000, 1'b0);
    send(ACT_FEAT, '0, '0, 16'h7fff, 1'b1);
    send(ACT_LD_U, '0, '0, 16'h1000, 1'b0);
    send(ACT_LD_V, '0, '0, 16'h1000, 1'b0);
    send(ACT_QUERY, '0, '0, '0, 1'b0);
    drain();

    set_config(127, 127, 0, 32767, -32768);
    random_items(25, 16);
    set_config(0, 0, 2, 0, -32768);
    random_items(25, 1);
    set_config(5, 11, 3, 200, 4096);
    random_items(25, 11);
    set_config(16, 16, 2, 1, -4096);
    random_items(25, 16);
    set_config(7, 3, 1, 0, 12345);
    random_items(25, 3);
    set_config(64, 1, 4, 16383, 32767);
    random_items(25, 1);

    $display("checked %0d input transactions and %0d result transactions", n_items, n_results);
    $display("over seven register settings including size, iteration and threshold extremes");
    if (fail_cnt == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/snpi_pkg.sv
design/snpi_in_if.sv
design/snpi_out_if.sv
design/snpi_div.sv
design/snpi_sqrt.sv
design/spectral_norm_power_iteration.sv
tb/sv/snpi_checker.sv
tb/sv/tb.sv
